>>> sv/tgd_pkg.sv
// Shared types and constants for the touch gesture detector.
// No dependencies; used by touch_gesture_detector_core and tgd_checker.
package tgd_pkg;

    // screen / panel coordinate width
    localparam int COORD_W = 12;
    // widest scaling numerator: 4095 * 4095 + 2047 < 2**24
    localparam int NUM_W   = 24;
    // reciprocal width for the constant divisor
    localparam int RCP_W   = NUM_W + 2;

    localparam int DEF_TOUCH_WIDTH   = 960;
    localparam int DEF_TOUCH_HEIGHT  = 540;
    localparam int DEF_SCREEN_WIDTH  = 540;
    localparam int DEF_SCREEN_HEIGHT = 960;

    localparam logic [15:0] DEF_DEBOUNCE_MS   = 16'd20;
    localparam logic [15:0] DEF_LONG_PRESS_MS = 16'd500;
    localparam logic [15:0] DEF_REPEAT_MS     = 16'd100;

    typedef enum logic [1:0] {
        REG_DEBOUNCE   = 2'd0,
        REG_LONG_PRESS = 2'd1,
        REG_REPEAT     = 2'd2
    } reg_index_t;

    typedef enum logic [2:0] {
        EV_PRESS       = 3'd0,
        EV_CLICK       = 3'd1,
        EV_LONG_START  = 3'd2,
        EV_LONG_REPEAT = 3'd3,
        EV_LONG_END    = 3'd4
    } event_kind_t;

    typedef enum logic [3:0] {
        PH_IDLE     = 4'b0001,
        PH_DEBOUNCE = 4'b0010,
        PH_PRESSED  = 4'b0100,
        PH_LONG     = 4'b1000
    } phase_t;

endpackage

>>> sv/touch_gesture_detector_core.sv
// Touch press / long-press detector: point scaling pipeline plus gesture state machine.
// Depends on tgd_pkg.
//
// One touch scan is accepted per clock cycle while s_tready is high; its event (if
// any) reaches the master side through the input register, clamp and scale product,
// reciprocal multiply for the rounded divide by the panel size, then the gesture
// state machine into the output register. The two multiplies of the scaling path
// sit in separate stages; the state machine keeps the rate at one scan per cycle
// unless an event waits on m_tready. A scan that produces no event leaves the
// pipeline without waiting on m_tready. Configuration writes are always accepted and
// should be issued only while no scan is in flight.
module touch_gesture_detector_core #(
    parameter int TOUCH_WIDTH   = tgd_pkg::DEF_TOUCH_WIDTH,
    parameter int TOUCH_HEIGHT  = tgd_pkg::DEF_TOUCH_HEIGHT,
    parameter int SCREEN_WIDTH  = tgd_pkg::DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = tgd_pkg::DEF_SCREEN_HEIGHT
) (
    input  logic         aclk,
    input  logic         aresetn,
    // scan input
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [63:0]  s_tdata,   // raw_x[15:0], raw_y[31:16], now_ms[63:32]
    input  logic [0:0]   s_tuser,   // touch_down[0]
    // events
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [111:0] m_tdata,   // first_x[11:0], first_y[23:12], last_x[35:24],
                                    // last_y[47:36], held_ms[79:48], stamp_ms[111:80]
    output logic [2:0]   m_tuser,   // event_kind[2:0]
    // configuration
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [15:0]  cfg_data
);

    localparam int CW = tgd_pkg::COORD_W;
    localparam int NW = tgd_pkg::NUM_W;
    localparam int RW = tgd_pkg::RCP_W;

    localparam logic [CW-1:0] TXM = CW'(TOUCH_WIDTH - 1);
    localparam logic [CW-1:0] TYM = CW'(TOUCH_HEIGHT - 1);

    // x comes from panel y, y from mirrored panel x
    localparam int DIV_X = TOUCH_HEIGHT - 1;
    localparam int DIV_Y = TOUCH_WIDTH - 1;
    localparam int SH_X  = NW + $clog2(DIV_X);
    localparam int SH_Y  = NW + $clog2(DIV_Y);
    localparam longint unsigned RCP_X_L = ((64'd1 << SH_X) + 64'(DIV_X) - 64'd1) / 64'(DIV_X);
    localparam longint unsigned RCP_Y_L = ((64'd1 << SH_Y) + 64'(DIV_Y) - 64'd1) / 64'(DIV_Y);
    localparam logic [RW-1:0] RCP_X = RW'(RCP_X_L);
    localparam logic [RW-1:0] RCP_Y = RW'(RCP_Y_L);

    localparam logic [NW-1:0] MUL_X = NW'(SCREEN_WIDTH - 1);
    localparam logic [NW-1:0] MUL_Y = NW'(SCREEN_HEIGHT - 1);
    localparam logic [NW-1:0] RND_X = NW'((TOUCH_HEIGHT - 1) / 2);
    localparam logic [NW-1:0] RND_Y = NW'((TOUCH_WIDTH - 1) / 2);

    // ---------------------------------------------------------------- config
    logic [15:0] debounce_reg, long_press_reg, repeat_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg   <= tgd_pkg::DEF_DEBOUNCE_MS;
            long_press_reg <= tgd_pkg::DEF_LONG_PRESS_MS;
            repeat_reg     <= tgd_pkg::DEF_REPEAT_MS;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                tgd_pkg::REG_DEBOUNCE:   debounce_reg   <= cfg_data;
                tgd_pkg::REG_LONG_PRESS: long_press_reg <= cfg_data;
                tgd_pkg::REG_REPEAT:     repeat_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------- handshake
    logic v0_reg, v1_reg, v2_reg;
    logic ld0, ld1, ld2, consume2, out_free;
    logic ev;

    assign out_free = !m_tvalid || m_tready;
    assign consume2 = v2_reg && (!ev || out_free);
    assign ld2      = !v2_reg || consume2;
    assign ld1      = !v1_reg || ld2;
    assign ld0      = !v0_reg || ld1;
    assign s_tready = ld0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (ld0) v0_reg <= s_tvalid;
            if (ld1) v1_reg <= v0_reg;
            if (ld2) v2_reg <= v1_reg;
        end
    end

    // ---------------------------------------------------------------- stage 0: input beat
    logic        down0_reg;
    logic [15:0] rx0_reg, ry0_reg;
    logic [31:0] now0_reg;

    always_ff @(posedge aclk) begin
        if (ld0) begin
            down0_reg <= s_tuser[0];
            rx0_reg   <= s_tdata[15:0];
            ry0_reg   <= s_tdata[31:16];
            now0_reg  <= s_tdata[63:32];
        end
    end

    // ---------------------------------------------------------------- stage 1: clamp, scale
    logic [CW-1:0] cx, cy;
    logic [NW-1:0] numx_next, numy_next;
    logic          down1_reg;
    logic [NW-1:0] numx1_reg, numy1_reg;
    logic [31:0]   now1_reg;

    always_comb begin
        if (rx0_reg[15])                  cx = '0;
        else if (rx0_reg[14:0] > 15'(TXM)) cx = TXM;
        else                              cx = rx0_reg[CW-1:0];
        if (ry0_reg[15])                  cy = '0;
        else if (ry0_reg[14:0] > 15'(TYM)) cy = TYM;
        else                              cy = ry0_reg[CW-1:0];
        numx_next = NW'(cy) * MUL_X + RND_X;
        numy_next = NW'(TXM - cx) * MUL_Y + RND_Y;
    end

    always_ff @(posedge aclk) begin
        if (ld1) begin
            down1_reg <= down0_reg;
            numx1_reg <= numx_next;
            numy1_reg <= numy_next;
            now1_reg  <= now0_reg;
        end
    end

    // ---------------------------------------------------------------- stage 2: divide by panel size
    // exact floor division: multiply by rounded-up reciprocal, keep the high bits
    logic [NW+RW-1:0] prodx, prody;
    logic             down2_reg;
    logic [CW-1:0]    sx2_reg, sy2_reg;
    logic [31:0]      now2_reg;

    assign prodx = (NW+RW)'(numx1_reg) * (NW+RW)'(RCP_X);
    assign prody = (NW+RW)'(numy1_reg) * (NW+RW)'(RCP_Y);

    always_ff @(posedge aclk) begin
        if (ld2) begin
            down2_reg <= down1_reg;
            sx2_reg   <= prodx[SH_X +: CW];
            sy2_reg   <= prody[SH_Y +: CW];
            now2_reg  <= now1_reg;
        end
    end

    // ---------------------------------------------------------------- stage 3: gesture FSM
    tgd_pkg::phase_t      phase_reg, phase_next;
    tgd_pkg::event_kind_t kind;
    logic [CW-1:0] origin_x_reg, origin_y_reg, latest_x_reg, latest_y_reg;
    logic [CW-1:0] origin_x_next, origin_y_next, latest_x_next, latest_y_next;
    logic [31:0]   start_reg, start_next, rep_time_reg, rep_time_next;
    logic [31:0]   held, since_rep;

    always_comb begin
        phase_next    = phase_reg;
        origin_x_next = origin_x_reg;
        origin_y_next = origin_y_reg;
        start_next    = start_reg;
        rep_time_next = rep_time_reg;
        latest_x_next = down2_reg ? sx2_reg : latest_x_reg;
        latest_y_next = down2_reg ? sy2_reg : latest_y_reg;
        held          = now2_reg - start_reg;
        since_rep     = now2_reg - rep_time_reg;
        ev            = 1'b0;
        kind          = tgd_pkg::EV_PRESS;
        unique case (phase_reg)
            tgd_pkg::PH_IDLE: begin
                if (down2_reg) begin
                    origin_x_next = sx2_reg;
                    origin_y_next = sy2_reg;
                    start_next    = now2_reg;
                    phase_next    = tgd_pkg::PH_DEBOUNCE;
                end
            end
            tgd_pkg::PH_DEBOUNCE: begin
                if (!down2_reg) begin
                    phase_next = tgd_pkg::PH_IDLE;
                end else if (held >= 32'(debounce_reg)) begin
                    phase_next = tgd_pkg::PH_PRESSED;
                    ev         = 1'b1;
                    kind       = tgd_pkg::EV_PRESS;
                end
            end
            tgd_pkg::PH_PRESSED: begin
                if (!down2_reg) begin
                    phase_next = tgd_pkg::PH_IDLE;
                    ev         = 1'b1;
                    kind       = tgd_pkg::EV_CLICK;
                end else if (held >= 32'(long_press_reg)) begin
                    rep_time_next = now2_reg;
                    phase_next    = tgd_pkg::PH_LONG;
                    ev            = 1'b1;
                    kind          = tgd_pkg::EV_LONG_START;
                end
            end
            tgd_pkg::PH_LONG: begin
                if (!down2_reg) begin
                    phase_next = tgd_pkg::PH_IDLE;
                    ev         = 1'b1;
                    kind       = tgd_pkg::EV_LONG_END;
                end else if (since_rep >= 32'(repeat_reg)) begin
                    rep_time_next = now2_reg;
                    ev            = 1'b1;
                    kind          = tgd_pkg::EV_LONG_REPEAT;
                end
            end
            default: phase_next = tgd_pkg::PH_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= tgd_pkg::PH_IDLE;
            origin_x_reg <= '0;
            origin_y_reg <= '0;
            latest_x_reg <= '0;
            latest_y_reg <= '0;
            start_reg    <= '0;
            rep_time_reg <= '0;
        end else if (consume2) begin
            phase_reg    <= phase_next;
            origin_x_reg <= origin_x_next;
            origin_y_reg <= origin_y_next;
            latest_x_reg <= latest_x_next;
            latest_y_reg <= latest_y_next;
            start_reg    <= start_next;
            rep_time_reg <= rep_time_next;
        end
    end

    // ---------------------------------------------------------------- output register
    logic m_tvalid_reg;
    logic [111:0] m_tdata_reg;
    logic [2:0]   m_tuser_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_free) begin
            m_tvalid_reg <= consume2 && ev;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && consume2 && ev) begin
            m_tuser_reg <= kind;
            m_tdata_reg <= {now2_reg, held, latest_y_next, latest_x_next,
                            origin_y_reg, origin_x_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

>>> sv/tgd_checker.sv
// Port-level checks for touch_gesture_detector_core, attached with bind.
// Depends on tgd_pkg and the top level's port list.
module tgd_checker #(
    parameter int SCREEN_WIDTH  = tgd_pkg::DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = tgd_pkg::DEF_SCREEN_HEIGHT
) (
    input logic         aclk,
    input logic         aresetn,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [111:0] m_tdata,
    input logic [2:0]   m_tuser,
    input logic         cfg_valid,
    input logic         cfg_ready
);

    localparam logic [11:0] XMAX = 12'(SCREEN_WIDTH - 1);
    localparam logic [11:0] YMAX = 12'(SCREEN_HEIGHT - 1);

    // a stalled event beat holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("event beat changed while stalled");

    // no event leaves in the cycle after reset
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("event valid right after reset");

    // event kind and scaled points stay on screen
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser <= tgd_pkg::EV_LONG_END
                     && m_tdata[11:0] <= XMAX && m_tdata[35:24] <= XMAX
                     && m_tdata[23:12] <= YMAX && m_tdata[47:36] <= YMAX)
        else $error("event kind or point out of range");

    // config writes never stall
    assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid |-> cfg_ready)
        else $error("config write stalled");

endmodule

bind touch_gesture_detector_core tgd_checker #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT)
) u_tgd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready)
);
